[sv/tvs_pkg.sv]
package tvs_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    RegLowerLimit    = 3'd0,
    RegUpperLimit    = 3'd1,
    RegSplitThresh   = 3'd2,
    RegLeftCoef      = 3'd3,
    RegRightCoef     = 3'd4
  } tvs_reg_e;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 64;

  // pipeline depth
  localparam int unsigned ProdStages = 3;
  localparam int unsigned SqrtSteps  = 32;
  localparam int unsigned Latency    = ProdStages + SqrtSteps + 1;

  // reset values of the configuration registers
  localparam logic [31:0] LowerLimitRst  = 32'h0000_0000;
  localparam logic [31:0] UpperLimitRst  = 32'h0001_0000;
  localparam logic [31:0] SplitThreshRst = 32'h8000_0000;
  localparam logic [63:0] LeftCoefRst    = 64'h0000_0000_8000_0000;
  localparam logic [63:0] RightCoefRst   = 64'h0000_0000_8000_0000;

  // side information that rides along with each item
  typedef struct packed {
    logic upper;
  } tvs_tag_t;

endpackage

[sv/tvs_prod.sv]
module tvs_prod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [31:0]       uniform_sample_i,
  input  logic [31:0]       split_threshold_i,
  input  logic [63:0]       left_coef_i,
  input  logic [63:0]       right_coef_i,
  output logic              valid_o,
  output tvs_pkg::tvs_tag_t tag_o,
  output logic [63:0]       prod_o
);
  import tvs_pkg::*;

  // stage 1: branch select and operand forming
  logic        s1_valid_q;
  tvs_tag_t    s1_tag_q, s1_tag_d;
  logic [31:0] s1_mul_q, s1_mul_d;
  logic [63:0] s1_coef_q, s1_coef_d;
  logic        s1_bypass_q, s1_bypass_d;

  always_comb begin
    s1_tag_d.upper = (uniform_sample_i >= split_threshold_i);
    s1_mul_d       = s1_tag_d.upper ? (32'd0 - uniform_sample_i) : uniform_sample_i;
    s1_coef_d      = s1_tag_d.upper ? right_coef_i : left_coef_i;
    // 1 - 0 is exactly one, so the product is the coefficient itself
    s1_bypass_d    = s1_tag_d.upper && (uniform_sample_i == 32'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q    <= s1_tag_d;
    s1_mul_q    <= s1_mul_d;
    s1_coef_q   <= s1_coef_d;
    s1_bypass_q <= s1_bypass_d;
  end

  // stage 2: two 32x32 partial products
  logic        s2_valid_q;
  tvs_tag_t    s2_tag_q;
  logic [63:0] s2_lo_q, s2_lo_d;
  logic [63:0] s2_hi_q, s2_hi_d;
  logic [63:0] s2_coef_q;
  logic        s2_bypass_q;

  assign s2_lo_d = 64'(s1_mul_q) * 64'(s1_coef_q[31:0]);
  assign s2_hi_d = 64'(s1_mul_q) * 64'(s1_coef_q[63:32]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_tag_q    <= s1_tag_q;
    s2_lo_q     <= s2_lo_d;
    s2_hi_q     <= s2_hi_d;
    s2_coef_q   <= s1_coef_q;
    s2_bypass_q <= s1_bypass_q;
  end

  // stage 3: top 64 bits of the product
  logic        s3_valid_q;
  tvs_tag_t    s3_tag_q;
  logic [63:0] s3_prod_q, s3_prod_d;

  assign s3_prod_d = s2_bypass_q ? s2_coef_q : (s2_hi_q + {32'd0, s2_lo_q[63:32]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_tag_q  <= s2_tag_q;
    s3_prod_q <= s3_prod_d;
  end

  assign valid_o = s3_valid_q;
  assign tag_o   = s3_tag_q;
  assign prod_o  = s3_prod_q;

endmodule

[sv/tvs_isqrt.sv]
module tvs_isqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  tvs_pkg::tvs_tag_t tag_i,
  input  logic [63:0]       radicand_i,
  output logic              valid_o,
  output tvs_pkg::tvs_tag_t tag_o,
  output logic [31:0]       root_o
);
  import tvs_pkg::*;

  // one result bit per stage, remainder and partial root carried along
  logic [63:0] rem_in  [SqrtSteps];
  logic [63:0] root_in [SqrtSteps];
  tvs_tag_t    tag_in  [SqrtSteps];
  logic        vld_in  [SqrtSteps];
  logic [63:0] rem_d   [SqrtSteps];
  logic [63:0] root_d  [SqrtSteps];
  logic [63:0] rem_q   [SqrtSteps];
  logic [63:0] root_q  [SqrtSteps];
  tvs_tag_t    tag_q   [SqrtSteps];
  logic        vld_q   [SqrtSteps];
  logic [63:0] step;
  logic [63:0] trial;
  logic        take;

  // stage k works on what stage k-1 registered, stage 0 on the input
  always_comb begin
    rem_in[0]  = radicand_i;
    root_in[0] = 64'd0;
    tag_in[0]  = tag_i;
    vld_in[0]  = valid_i;
    for (int k = 1; k < SqrtSteps; k++) begin
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
      tag_in[k]  = tag_q[k-1];
      vld_in[k]  = vld_q[k-1];
    end
  end

  // trial subtract of the next bit pair in every stage
  always_comb begin
    step  = '0;
    trial = '0;
    take  = 1'b0;
    for (int k = 0; k < SqrtSteps; k++) begin
      step      = 64'd1 << (62 - 2 * k);
      trial     = root_in[k] + step;
      take      = (rem_in[k] >= trial);
      rem_d[k]  = take ? (rem_in[k] - trial) : rem_in[k];
      root_d[k] = take ? ((root_in[k] >> 1) + step) : (root_in[k] >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SqrtSteps; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < SqrtSteps; k++) begin
        vld_q[k] <= vld_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SqrtSteps; k++) begin
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
      tag_q[k]  <= tag_in[k];
    end
  end

  assign valid_o = vld_q[SqrtSteps-1];
  assign tag_o   = tag_q[SqrtSteps-1];
  assign root_o  = root_q[SqrtSteps-1][31:0];

  // a root only leaves if a radicand went in one full pipe earlier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(valid_i, SqrtSteps))
    else $error("isqrt: result without matching entry");

endmodule

[sv/triangular_variate_sampler_core.sv]
// Triangular variate sampler: maps one uniform sample (unsigned Q0.32) to a
// triangular-distributed sample (signed Q16.16) by inverse transform. Below
// the split threshold the result is lower_limit + sqrt(u * left_coef), at or
// above it upper_limit - sqrt((1 - u) * right_coef), saturated to 32 bits;
// upper_branch_o tells which side was used. Software loads the threshold and
// both coefficients through the configuration channel (index 0 lower limit,
// 1 upper limit, 2 split threshold, 3 left coef, 4 right coef; other indexes
// are ignored) and must only do so while no item is in flight. A new item is
// taken on every cycle that start_i is high: busy_o never rises, the block
// is fully pipelined. Each result leaves as a one-cycle valid_o pulse; there
// is no back-pressure, so the receiver has to capture it on that cycle. The
// pipeline is a 32 stage bit-by-bit square root, behind three stages of
// operand select and split 32x32 multiplication, plus one stage for the final
// add and clamp.
module triangular_variate_sampler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item input
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [31:0]                   uniform_sample_i,
  // result output
  output logic                          valid_o,
  output logic [31:0]                   sample_value_o,
  output logic                          upper_branch_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tvs_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [tvs_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tvs_pkg::*;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [31:0] lower_limit_q;
  logic [31:0] upper_limit_q;
  logic [31:0] split_threshold_q;
  logic [63:0] left_coef_q;
  logic [63:0] right_coef_q;
  logic        cfg_we;
  tvs_reg_e    cfg_reg;

  // writes are always taken, one per cycle
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_reg     = tvs_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_limit_q     <= LowerLimitRst;
      upper_limit_q     <= UpperLimitRst;
      split_threshold_q <= SplitThreshRst;
      left_coef_q       <= LeftCoefRst;
      right_coef_q      <= RightCoefRst;
    end else if (cfg_we) begin
      case (cfg_reg)
        RegLowerLimit:  lower_limit_q     <= cfg_data_i[31:0];
        RegUpperLimit:  upper_limit_q     <= cfg_data_i[31:0];
        RegSplitThresh: split_threshold_q <= cfg_data_i[31:0];
        RegLeftCoef:    left_coef_q       <= cfg_data_i;
        RegRightCoef:   right_coef_q      <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // item intake: fully pipelined, never stalls
  // ---------------------------------------------------------------------
  logic in_accept;

  assign busy_o    = 1'b0;
  assign in_accept = start_i && !busy_o;

  // ---------------------------------------------------------------------
  // product: branch pick, (1-u) forming, 32x64 product top half
  // ---------------------------------------------------------------------
  logic        prod_valid;
  tvs_tag_t    prod_tag;
  logic [63:0] prod_value;

  tvs_prod u_prod (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (in_accept),
    .uniform_sample_i  (uniform_sample_i),
    .split_threshold_i (split_threshold_q),
    .left_coef_i       (left_coef_q),
    .right_coef_i      (right_coef_q),
    .valid_o           (prod_valid),
    .tag_o             (prod_tag),
    .prod_o            (prod_value)
  );

  // ---------------------------------------------------------------------
  // floor square root of the Q32.32 product, gives Q16.16
  // ---------------------------------------------------------------------
  logic        root_valid;
  tvs_tag_t    root_tag;
  logic [31:0] root_value;

  tvs_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (prod_valid),
    .tag_i      (prod_tag),
    .radicand_i (prod_value),
    .valid_o    (root_valid),
    .tag_o      (root_tag),
    .root_o     (root_value)
  );

  // ---------------------------------------------------------------------
  // final stage: add to or subtract from the limit, then clamp
  // ---------------------------------------------------------------------
  logic [31:0] base_limit;
  logic [33:0] base_ext;
  logic [33:0] root_ext;
  logic [33:0] sum;
  logic [31:0] sample_d;
  logic        out_valid_q;
  logic [31:0] sample_q;
  logic        upper_q;

  always_comb begin
    base_limit = root_tag.upper ? upper_limit_q : lower_limit_q;
    base_ext   = {{2{base_limit[31]}}, base_limit};
    root_ext   = {2'b00, root_value};
    sum        = root_tag.upper ? (base_ext - root_ext) : (base_ext + root_ext);
    // in range when the top three bits agree, otherwise clamp by sign
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      sample_d = sum[31:0];
    end else if (sum[33]) begin
      sample_d = 32'h8000_0000;
    end else begin
      sample_d = 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= root_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    upper_q  <= root_tag.upper;
  end

  assign valid_o        = out_valid_q;
  assign sample_value_o = sample_q;
  assign upper_branch_o = upper_q;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  // every result pulse traces back to an item taken one full pipeline earlier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(in_accept, Latency))
    else $error("sampler: result pulse without matching item");

  // lower side only ever adds a non-negative root to the lower limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !upper_branch_o) |-> ($signed(sample_value_o) >= $signed(lower_limit_q)))
    else $error("sampler: lower-side result below lower limit");

  // upper side only ever subtracts a non-negative root from the upper limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && upper_branch_o) |-> ($signed(sample_value_o) <= $signed(upper_limit_q)))
    else $error("sampler: upper-side result above upper limit");

endmodule

[dv/tvs_result_checker.sv]
`timescale 1ns / 1ps

module tvs_result_checker
  import tvs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_o,
  input  logic [31:0]          uniform_sample_i,
  input  logic                 valid_o,
  input  logic [31:0]          sample_value_o,
  input  logic                 upper_branch_o,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output int                   fail_count_o,
  output int                   outstanding_o
);

  localparam longint SampleMax = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SampleMin = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [31:0] uniform;
    logic [31:0] value;
    logic        upper;
  } sample_t;

  logic [31:0] lower_limit_q;
  logic [31:0] upper_limit_q;
  logic [31:0] split_thresh_q;
  logic [63:0] left_coef_q;
  logic [63:0] right_coef_q;

  sample_t expected_samples[$];
  sample_t head;
  int      mismatches;

  assign fail_count_o = mismatches;

  // floor square root, one result bit at a time from the top
  function automatic logic [31:0] floor_root(input logic [63:0] x);
    logic [31:0] root;
    logic [31:0] cand;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      cand = root | (32'd1 << i);
      if (64'(cand) * 64'(cand) <= x) root = cand;
    end
    return root;
  endfunction

  function automatic sample_t triangular_sample(input logic [31:0] u);
    logic [32:0] weight;
    logic [63:0] coef;
    logic [96:0] full;
    logic [31:0] root;
    longint      sum;
    sample_t     s;
    s.uniform = u;
    s.upper   = (u >= split_thresh_q);
    // 1 - u needs 33 bits, it is exactly 1.0 for a zero uniform
    weight    = s.upper ? (33'h1_0000_0000 - {1'b0, u}) : {1'b0, u};
    coef      = s.upper ? right_coef_q : left_coef_q;
    full      = 97'(weight) * 97'(coef);
    root      = floor_root(full[95:32]);
    if (s.upper) begin
      sum = longint'($signed(upper_limit_q)) - longint'(root);
    end else begin
      sum = longint'($signed(lower_limit_q)) + longint'(root);
    end
    if (sum > SampleMax) sum = SampleMax;
    if (sum < SampleMin) sum = SampleMin;
    s.value = sum[31:0];
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] u,
                                 input logic [31:0] got, input logic [31:0] want);
    $display("%0t: %s mismatch for uniform %h: got %h, expected %h",
             $time, what, u, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_limit_q  = LowerLimitRst;
      upper_limit_q  = UpperLimitRst;
      split_thresh_q = SplitThreshRst;
      left_coef_q    = LeftCoefRst;
      right_coef_q   = RightCoefRst;
      expected_samples.delete();
      outstanding_o <= 0;
    end else begin
      if (valid_o) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected result", 'x, sample_value_o, 'x);
        end else begin
          head = expected_samples.pop_front();
          if (sample_value_o !== head.value)
            report_mismatch("sample_value", head.uniform, sample_value_o, head.value);
          if (upper_branch_o !== head.upper)
            report_mismatch("upper_branch", head.uniform, 32'(upper_branch_o),
                            32'(head.upper));
        end
      end
      if (start_i && !busy_o) expected_samples.push_back(triangular_sample(uniform_sample_i));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegLowerLimit:  lower_limit_q  = cfg_data_i[31:0];
          RegUpperLimit:  upper_limit_q  = cfg_data_i[31:0];
          RegSplitThresh: split_thresh_q = cfg_data_i[31:0];
          RegLeftCoef:    left_coef_q    = cfg_data_i;
          RegRightCoef:   right_coef_q   = cfg_data_i;
          default: ;
        endcase
      end
      outstanding_o <= expected_samples.size();
    end
  end

endmodule

[dv/tb_triangular_variate_sampler_core.sv]
`timescale 1ns / 1ps

module tb_triangular_variate_sampler_core;
  import tvs_pkg::*;

  // no accepted item, result or register write for this many cycles means a hang
  localparam int unsigned StallLimit    = 1000;
  localparam int unsigned Phases        = 9;
  localparam int unsigned ItemsPerPhase = 54;

  // indexes past the register list, writes there must be dropped
  localparam logic [CfgIndexW-1:0] FirstUnusedIdx = CfgIndexW'(RegRightCoef) + 1'b1;

  typedef enum {
    ShapeTriangle,    // consistent a, c, b with derived threshold and coefficients
    ShapeRandom,      // every register random, mostly inconsistent
    ShapeSatHigh,     // limits swapped to the rails so both sides clamp
    ShapeZeroThresh,  // no uniform is below the threshold
    ShapeFullThresh   // full threshold, widest limits and coefficients
  } shape_e;

  typedef struct {
    logic [31:0] lower;
    logic [31:0] upper;
    logic [31:0] thresh;
    logic [63:0] left;
    logic [63:0] right;
  } setting_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [31:0]          uniform_sample_i;
  logic                 valid_o;
  logic [31:0]          sample_value_o;
  logic                 upper_branch_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  int          fail_count;
  int          outstanding;
  int unsigned stall_cycles;
  logic [31:0] cur_thresh;

  shape_e phase_plan [Phases] = '{ShapeTriangle, ShapeRandom, ShapeTriangle, ShapeSatHigh,
                                  ShapeTriangle, ShapeZeroThresh, ShapeTriangle,
                                  ShapeFullThresh, ShapeTriangle};

  // uniform corners: zero, smallest step, just under and at one half, largest
  logic [31:0] edge_uniforms [5] = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
                                     32'h8000_0000, 32'hFFFF_FFFF};

  triangular_variate_sampler_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .uniform_sample_i (uniform_sample_i),
    .valid_o          (valid_o),
    .sample_value_o   (sample_value_o),
    .upper_branch_o   (upper_branch_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  tvs_result_checker result_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .uniform_sample_i (uniform_sample_i),
    .valid_o          (valid_o),
    .sample_value_o   (sample_value_o),
    .upper_branch_o   (upper_branch_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hang detector, restarted by any handshake and held off during reset
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // present one item and hold it until taken; start_i stays high for a following item
  task automatic drive_item(input logic [31:0] u);
    start_i          <= 1'b1;
    uniform_sample_i <= u;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // sender gap, with junk on the data port
  task automatic idle_burst(input int unsigned cycles);
    start_i          <= 1'b0;
    uniform_sample_i <= $urandom();
    repeat (cycles) @(posedge clk_i);
  endtask

  // stop sending and wait for the last result; the first edge lets the
  // outstanding count catch up with an item taken at the current edge
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // cfg_valid_i is left high so back-to-back writes never drop it within one step
  task automatic cfg_write(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // registers only change with nothing in flight
  task automatic load_setting(input setting_t s);
    wait_drained();
    // 32-bit registers get random upper data bits that must be dropped
    cfg_write(RegLowerLimit, {$urandom(), s.lower});
    if ($urandom_range(0, 1))
      cfg_write(FirstUnusedIdx + CfgIndexW'($urandom_range(0, 2)), {$urandom(), $urandom()});
    cfg_write(RegUpperLimit, {$urandom(), s.upper});
    cfg_write(RegSplitThresh, {$urandom(), s.thresh});
    cfg_write(RegLeftCoef, s.left);
    cfg_write(RegRightCoef, s.right);
    if ($urandom_range(0, 1))
      cfg_write(FirstUnusedIdx + CfgIndexW'($urandom_range(0, 2)), {$urandom(), $urandom()});
    cfg_valid_i <= 1'b0;
    cur_thresh  = s.thresh;
  endtask

  function automatic setting_t make_setting(input shape_e shape);
    setting_t        s;
    longint          lo;
    longint unsigned span;
    longint unsigned mode_off;
    longint unsigned thr;
    s.lower  = $urandom();
    s.upper  = $urandom();
    s.thresh = $urandom();
    s.left   = {$urandom(), $urandom()};
    s.right  = {$urandom(), $urandom()};
    case (shape)
      ShapeTriangle: begin
        // spans from tiny to about 2^14, all Q16.16; products of raw
        // Q16.16 distances are already Q32.32
        span     = $urandom_range(1, 32'd1 << $urandom_range(1, 30));
        lo       = longint'($signed($urandom())) >>> 2;
        mode_off = $urandom_range(0, 32'(span));
        thr      = (mode_off << 32) / span;
        if (thr > 64'h0000_0000_FFFF_FFFF) thr = 64'h0000_0000_FFFF_FFFF;
        s.lower  = 32'(lo);
        s.upper  = 32'(lo + longint'(span));
        s.thresh = thr[31:0];
        s.left   = span * mode_off;
        s.right  = span * (span - mode_off);
      end
      ShapeSatHigh: begin
        s.lower = 32'h7FFF_FFFF;
        s.upper = 32'h8000_0000;
        if ($urandom_range(0, 1)) s.left = '1;
        if ($urandom_range(0, 1)) s.right = '1;
      end
      ShapeZeroThresh: begin
        s.thresh = '0;
        if ($urandom_range(0, 1)) s.right = '1;
      end
      ShapeFullThresh: begin
        s.lower  = 32'h8000_0000;
        s.upper  = 32'h7FFF_FFFF;
        s.thresh = '1;
        s.left   = '1;
        s.right  = '1;
      end
      default: ;
    endcase
    return s;
  endfunction

  // mostly random, with weight on the rails and on the branch boundary
  function automatic logic [31:0] pick_uniform(input logic [31:0] thr);
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return thr - 32'($urandom_range(0, 3));
      3:       return thr + 32'($urandom_range(0, 3));
      4:       return 32'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    setting_t s;
    rst_ni           <= 1'b0;
    start_i          <= 1'b0;
    uniform_sample_i <= '0;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= RegLowerLimit;
    cfg_data_i       <= '0;
    cur_thresh       = SplitThreshRst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of every register: corners on both sides of one half
    foreach (edge_uniforms[i]) drive_item(edge_uniforms[i]);

    // limits on the wrong rails with full coefficients, both sides clamp
    s = '{lower: 32'h7FFF_FFFF, upper: 32'h8000_0000, thresh: 32'h8000_0000,
          left: '1, right: '1};
    load_setting(s);
    foreach (edge_uniforms[i]) drive_item(edge_uniforms[i]);

    // zero threshold, always upper side; a zero uniform takes right_coef whole
    s = '{lower: 32'h0, upper: 32'h0, thresh: 32'h0, left: '1, right: '1};
    load_setting(s);
    drive_item(32'h0000_0000);
    drive_item(32'h0000_0001);
    drive_item(32'hFFFF_FFFF);

    // zero coefficients return the limits themselves
    s = '{lower: 32'h8000_0000, upper: 32'h7FFF_FFFF, thresh: 32'h8000_0000,
          left: '0, right: '0};
    load_setting(s);
    drive_item(32'h0000_0000);
    drive_item(32'hFFFF_FFFF);

    // random part, one register setting per phase, no gaps in the last one
    for (int p = 0; p < Phases; p++) begin
      load_setting(make_setting(phase_plan[p]));
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (p == Phases / 2 && n == ItemsPerPhase / 2) begin
          // let the pipeline run dry once in the middle of a stream
          wait_drained();
        end else if (p < Phases - 1 && $urandom_range(0, 7) == 0) begin
          idle_burst($urandom_range(1, 16));
        end
        drive_item(pick_uniform(cur_thresh));
      end
    end

    wait_drained();
    // catch any stray result after the last expected one
    repeat (Latency + 4) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
